FILE: src/bbs_pkg.sv
// Shared types and constants for the byte block statistics block.
// Used by bbs_div and byte_block_statistics; no other dependencies.
package bbs_pkg;

  // Block capacity and the widths that follow from it
  localparam int MAX_ITEMS = 64;
  localparam int CNT_W     = $clog2(MAX_ITEMS + 1);  // kept count, histogram entry
  localparam int SUM_W     = CNT_W + 8;              // running sum of bytes
  localparam int DVD_W     = CNT_W + 9;              // 2*sum + count
  localparam int QUOT_W    = 8;                      // mean fits one byte
  localparam int HIST_D    = 256;                    // one bin per byte value
  localparam int HIST_AW   = $clog2(HIST_D);
  localparam int CNT_OUT_W = 7;

  // Input word
  typedef struct packed {
    logic [7:0] sample;
    logic       last_item;
  } in_t;

  // Result word
  typedef struct packed {
    logic [7:0]           minimum;
    logic [7:0]           maximum;
    logic [QUOT_W-1:0]    mean;
    logic [7:0]           median;
    logic [CNT_OUT_W-1:0] item_count;
    logic                 overflow;
  } out_t;

  // Control states, one-hot
  typedef enum logic [5:0] {
    ST_CLEAR = 6'b000001,
    ST_RUN   = 6'b000010,
    ST_FLUSH = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_TAIL  = 6'b010000,
    ST_OUT   = 6'b100000
  } state_e;

endpackage

FILE: src/bbs_div.sv
// Restoring divider for the block mean: one quotient bit per cycle.
// Depends on bbs_pkg for the operand and quotient widths.
module bbs_div (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [bbs_pkg::DVD_W-1:0] dividend_i,
  input  logic [bbs_pkg::CNT_W:0]   divisor_i,
  output logic [bbs_pkg::QUOT_W-1:0] quot_o,
  output logic                     done_o
);
  import bbs_pkg::*;

  localparam int STEP_W = $clog2(QUOT_W);

  logic              run_q;
  logic              done_q;
  logic [STEP_W-1:0] step_q;
  logic [DVD_W-1:0]  rem_q;
  logic [DVD_W-1:0]  dsh_q;
  logic [QUOT_W-1:0] quot_q;
  logic              ge;

  // Quotient is known to stay below 2^QUOT_W, so only QUOT_W trial subtracts
  assign ge = (rem_q >= dsh_q);

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      run_q  <= 1'b1;
      done_q <= 1'b0;
      step_q <= '0;
    end else if (run_q) begin
      step_q <= step_q + STEP_W'(1);
      if (step_q == STEP_W'(QUOT_W - 1)) begin
        run_q  <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= dividend_i;
      dsh_q  <= DVD_W'({divisor_i, {(QUOT_W - 1){1'b0}}});
      quot_q <= '0;
    end else if (run_q) begin
      if (ge) begin
        rem_q <= rem_q - dsh_q;
      end
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[QUOT_W-2:0], ge};
    end
  end

  assign quot_o = quot_q;
  assign done_o = done_q;

endmodule

FILE: src/byte_block_statistics.sv
// Top level of the byte block statistics block: histogram memory and control.
// Depends on bbs_pkg and bbs_div.
//
// Bytes of a block are taken one per cycle (start_i while busy_o is low);
// item_i.last_item marks the final byte. After the last byte the block is
// busy: a flush state commits the final histogram update, the walk state
// reads the 256 bins through the memory read port (finding the median and
// zeroing each bin through the write port on the way), a tail state takes
// the last bin, and the result word is shown for a single cycle with done_o
// high. The receiver cannot hold the result off; it is valid for that cycle
// only. The mean is computed by a bit-serial divider alongside the walk.
// After reset the histogram is zeroed by a sweep of all 256 bins with busy_o
// high. Bytes past the MAX_ITEMS capacity are dropped and flagged in overflow.
module byte_block_statistics (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  bbs_pkg::in_t  item_i,
  output logic          busy_o,
  output logic          done_o,
  output bbs_pkg::out_t res_o
);
  import bbs_pkg::*;

  state_e state_q, state_d;

  logic [HIST_AW-1:0] walk_q;
  logic               acc;
  logic               keep;

  // Histogram memory
  logic [CNT_W-1:0]   mem [HIST_D];
  logic [CNT_W-1:0]   mem_rdata_q;
  logic               mem_we;
  logic [HIST_AW-1:0] mem_waddr;
  logic [CNT_W-1:0]   mem_wdata;
  logic [HIST_AW-1:0] mem_raddr;

  // Read-modify-write and forwarding of the previous write
  logic               upd_v_q;
  logic [HIST_AW-1:0] upd_addr_q;
  logic               fw_v_q;
  logic [HIST_AW-1:0] fw_addr_q;
  logic [CNT_W-1:0]   fw_data_q;
  logic [CNT_W-1:0]   cur_cnt;

  // Running statistics
  logic [SUM_W-1:0]   sum_q;
  logic [7:0]         min_q;
  logic [7:0]         max_q;
  logic [CNT_W-1:0]   cnt_q;
  logic               drop_q;

  // Median walk
  logic               walk_v_q;
  logic [HIST_AW-1:0] walk_idx_q;
  logic [CNT_W-1:0]   cum_q;
  logic [CNT_W-1:0]   cum_d;
  logic [CNT_W-1:0]   r_lo;
  logic [CNT_W-1:0]   r_hi;
  logic [7:0]         a_q;
  logic [7:0]         b_q;
  logic               a_hit_q;
  logic               b_hit_q;
  logic [8:0]         med_sum;

  // Mean divider
  logic               div_start;
  logic [DVD_W-1:0]   dividend;
  logic [CNT_W:0]     divisor;
  logic [QUOT_W-1:0]  div_quot;
  logic               div_done;

  assign busy_o = (state_q != ST_RUN);
  assign acc    = start_i && (state_q == ST_RUN);
  assign keep   = acc && (cnt_q < CNT_W'(MAX_ITEMS));

  // Control state machine
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (walk_q == HIST_AW'(HIST_D - 1)) state_d = ST_RUN;
      end
      ST_RUN: begin
        if (acc && item_i.last_item) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (walk_q == HIST_AW'(HIST_D - 1)) state_d = ST_TAIL;
      end
      ST_TAIL: begin
        if (div_done) state_d = ST_OUT;
      end
      ST_OUT: begin
        state_d = ST_RUN;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      walk_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR || state_q == ST_WALK) begin
        walk_q <= walk_q + HIST_AW'(1);
      end else begin
        walk_q <= '0;
      end
    end
  end

  // Forward the write of the previous cycle when the same bin is updated again
  assign cur_cnt = (fw_v_q && fw_addr_q == upd_addr_q) ? fw_data_q : mem_rdata_q;

  // Memory port control: bin update, or zeroing during sweep and walk
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = upd_addr_q;
    mem_wdata = cur_cnt + CNT_W'(1);
    if (upd_v_q) begin
      mem_we = 1'b1;
    end else if (state_q == ST_CLEAR || state_q == ST_WALK) begin
      mem_we    = 1'b1;
      mem_waddr = walk_q;
      mem_wdata = '0;
    end
  end

  assign mem_raddr = (state_q == ST_WALK) ? walk_q : item_i.sample;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_q <= mem[mem_raddr];
  end

  // Update pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upd_v_q <= 1'b0;
      fw_v_q  <= 1'b0;
    end else begin
      upd_v_q <= keep;
      fw_v_q  <= upd_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    upd_addr_q <= item_i.sample;
    fw_addr_q  <= upd_addr_q;
    fw_data_q  <= mem_wdata;
  end

  // Running sum, min, max, count and drop flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      min_q  <= 8'hFF;
      max_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (state_q == ST_OUT) begin
      sum_q  <= '0;
      min_q  <= 8'hFF;
      max_q  <= '0;
      cnt_q  <= '0;
      drop_q <= 1'b0;
    end else if (keep) begin
      sum_q <= sum_q + SUM_W'(item_i.sample);
      if (item_i.sample < min_q) min_q <= item_i.sample;
      if (item_i.sample > max_q) max_q <= item_i.sample;
      cnt_q <= cnt_q + CNT_W'(1);
    end else if (acc) begin
      drop_q <= 1'b1;
    end
  end

  // Median walk: ranks of the two middle values
  assign r_lo  = (cnt_q - CNT_W'(1)) >> 1;
  assign r_hi  = cnt_q >> 1;
  assign cum_d = cum_q + mem_rdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_v_q <= 1'b0;
      cum_q    <= '0;
      a_hit_q  <= 1'b0;
      b_hit_q  <= 1'b0;
    end else begin
      walk_v_q <= (state_q == ST_WALK);
      if (state_q == ST_OUT) begin
        cum_q   <= '0;
        a_hit_q <= 1'b0;
        b_hit_q <= 1'b0;
      end else if (walk_v_q) begin
        cum_q <= cum_d;
        if (!a_hit_q && cum_d > r_lo) a_hit_q <= 1'b1;
        if (!b_hit_q && cum_d > r_hi) b_hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    walk_idx_q <= walk_q;
    if (walk_v_q && !a_hit_q && cum_d > r_lo) a_q <= walk_idx_q;
    if (walk_v_q && !b_hit_q && cum_d > r_hi) b_q <= walk_idx_q;
  end

  // Mean = floor((2*sum + count) / (2*count)), started once the block is complete
  assign div_start = (state_q == ST_FLUSH);
  assign dividend  = DVD_W'({sum_q, 1'b0}) + DVD_W'(cnt_q);
  assign divisor   = {cnt_q, 1'b0};

  bbs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (divisor),
    .quot_o     (div_quot),
    .done_o     (div_done)
  );

  // Result word
  assign med_sum = {1'b0, a_q} + {1'b0, b_q} + 9'd1;
  assign done_o  = (state_q == ST_OUT);

  always_comb begin
    res_o.minimum    = min_q;
    res_o.maximum    = max_q;
    res_o.mean       = div_quot;
    res_o.median     = med_sum[8:1];
    res_o.item_count = CNT_OUT_W'(cnt_q);
    res_o.overflow   = drop_q;
  end

`ifndef ASSERT_OFF
  // Median and mean of a nonempty block lie between its min and max
  a_median_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.median >= res_o.minimum && res_o.median <= res_o.maximum))
    else $error("median outside min/max range");

  a_mean_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.mean >= res_o.minimum && res_o.mean <= res_o.maximum))
    else $error("mean outside min/max range");

  // The last byte of a block locks out new words
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && item_i.last_item) |=> busy_o)
    else $error("not busy after last byte");

  // The divider has finished whenever a result is shown
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> div_done)
    else $error("result shown before mean is ready");
`endif

endmodule
